// ----- hw/rtl/rgbab_pkg.sv -----
// Shared types and constants for the RGBA8 pixel alpha blend unit.
`timescale 1ns / 1ps

package rgbab_pkg;

  // Channel and arithmetic widths.
  localparam int CH_W   = 8;
  localparam int WGT_W  = 9;
  localparam int PROD_W = 17;
  localparam int MIX_W  = 25;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Weight constants.
  localparam logic [WGT_W-1:0] WEIGHT_ONE   = 9'd256;
  localparam logic [WGT_W-1:0] WEIGHT_RESET = 9'd128;

  // Register indexes, taken from paddr[2].
  localparam logic REG_OVERLAY = 1'b0;
  localparam logic REG_WEIGHT  = 1'b1;

  // One input item: a pair of co-located RGBA8 pixels.
  typedef struct packed {
    logic [CH_W-1:0] first_red;
    logic [CH_W-1:0] first_green;
    logic [CH_W-1:0] first_blue;
    logic [CH_W-1:0] first_alpha;
    logic [CH_W-1:0] second_red;
    logic [CH_W-1:0] second_green;
    logic [CH_W-1:0] second_blue;
    logic [CH_W-1:0] second_alpha;
  } pixel_pair_t;

  // One result item: a blended RGBA8 pixel.
  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_alpha;
  } result_t;

endpackage

// ----- hw/rtl/rgba_pixel_alpha_blend_unit.sv -----
// Top level of the RGBA8 pixel alpha blend unit: registers, pipeline and result port.
`timescale 1ns / 1ps
//
// Blends two co-located RGBA8 pixels into one RGBA8 pixel.
// Input: an item (src) is taken at a rising edge with start high and busy low.
// busy is low at all times except during reset, so one item can enter every
// cycle and a new item may follow the previous one with no gap.
// Output: result is shown for exactly one cycle with done high, once the item
// has passed the three pipeline stages (weight products, color products, sum).
// Throughput is one item per cycle.
// The receiver cannot stall the block; every result appears once, in order.
// Configuration: APB port, overlay_mode at byte address 0 and blend_weight at
// byte address 4. pready is always high. Write registers only while no item
// is in flight. A blend_weight above 256 acts as 256.
// Reset (rst, synchronous) clears the pipeline valid bits, sets overlay_mode
// to 0 and blend_weight to 128. Items in flight at reset are dropped.
//
module rgba_pixel_alpha_blend_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  rgbab_pkg::pixel_pair_t        src,
  output logic                          done,
  output rgbab_pkg::result_t            result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rgbab_pkg::ADDR_W-1:0]  paddr,
  input  logic [rgbab_pkg::DATA_W-1:0]  pwdata,
  output logic [rgbab_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);

  // Configuration registers.
  logic                          overlay_mode;
  logic [rgbab_pkg::WGT_W-1:0]   blend_weight;

  // Clamped weights.
  logic [rgbab_pkg::WGT_W-1:0]   wa;
  logic [rgbab_pkg::WGT_W-1:0]   wb;

  // Stage 1.
  logic                          valid1;
  logic                          mode1;
  rgbab_pkg::pixel_pair_t        pix1;
  logic [rgbab_pkg::PROD_W-1:0]  p1;
  logic [rgbab_pkg::PROD_W-1:0]  p2;

  // Channel multiplicands.
  logic [rgbab_pkg::WGT_W-1:0]   ovl_w;
  logic [rgbab_pkg::WGT_W-1:0]   ovl_nw;
  logic [rgbab_pkg::PROD_W-1:0]  m1;
  logic [rgbab_pkg::PROD_W-1:0]  m2;
  logic [rgbab_pkg::PROD_W-1:0]  alpha_sum;

  // Stages 2 and 3.
  logic                          valid2;
  logic                          valid3;
  logic [rgbab_pkg::CH_W-1:0]    alpha2;
  logic [rgbab_pkg::CH_W-1:0]    alpha3;
  logic [rgbab_pkg::CH_W-1:0]    red3;
  logic [rgbab_pkg::CH_W-1:0]    green3;
  logic [rgbab_pkg::CH_W-1:0]    blue3;

  logic                          accept;
  logic                          cfg_write;

  assign busy   = rst;
  assign pready = 1'b1;
  assign accept = start && !busy;
  assign cfg_write = psel && penable && pwrite && pready;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      overlay_mode <= 1'b0;
      blend_weight <= rgbab_pkg::WEIGHT_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        rgbab_pkg::REG_OVERLAY: overlay_mode <= pwdata[0];
        rgbab_pkg::REG_WEIGHT:  blend_weight <= pwdata[rgbab_pkg::WGT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (paddr[2])
      rgbab_pkg::REG_OVERLAY: prdata = {{(rgbab_pkg::DATA_W-1){1'b0}}, overlay_mode};
      rgbab_pkg::REG_WEIGHT:
        prdata = {{(rgbab_pkg::DATA_W-rgbab_pkg::WGT_W){1'b0}}, blend_weight};
      default: prdata = '0;
    endcase
  end

  // Saturate the weight to 256 and form its complement.
  assign wa = (blend_weight > rgbab_pkg::WEIGHT_ONE) ? rgbab_pkg::WEIGHT_ONE : blend_weight;
  assign wb = rgbab_pkg::WEIGHT_ONE - wa;

  // Stage 1: alpha times weight for both pixels.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else begin
      valid1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    pix1  <= src;
    mode1 <= overlay_mode;
    p1    <= {{(rgbab_pkg::PROD_W-rgbab_pkg::CH_W){1'b0}}, src.first_alpha} *
             {{(rgbab_pkg::PROD_W-rgbab_pkg::WGT_W){1'b0}}, wb};
    p2    <= {{(rgbab_pkg::PROD_W-rgbab_pkg::CH_W){1'b0}}, src.second_alpha} *
             {{(rgbab_pkg::PROD_W-rgbab_pkg::WGT_W){1'b0}}, wa};
  end

  // Overlay weight from the second alpha, and the color multiplicands.
  assign ovl_w  = {1'b0, p2[15:8]};
  assign ovl_nw = rgbab_pkg::WEIGHT_ONE - ovl_w;
  assign m1 = mode1 ? {{(rgbab_pkg::PROD_W-rgbab_pkg::WGT_W){1'b0}}, ovl_nw} : p1;
  assign m2 = mode1 ? {{(rgbab_pkg::PROD_W-rgbab_pkg::WGT_W){1'b0}}, ovl_w}  : p2;
  assign alpha_sum = p1 + p2;

  // Stage 2 and 3: alpha path and valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
      valid3 <= 1'b0;
    end else begin
      valid2 <= valid1;
      valid3 <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    alpha2 <= mode1 ? pix1.first_alpha : alpha_sum[15:8];
    alpha3 <= alpha2;
  end

  // Color channel mixers.
  rgbab_chan u_red (
    .clk  (clk),
    .mode (mode1),
    .c1   (pix1.first_red),
    .c2   (pix1.second_red),
    .m1   (m1),
    .m2   (m2),
    .ch   (red3)
  );

  rgbab_chan u_green (
    .clk  (clk),
    .mode (mode1),
    .c1   (pix1.first_green),
    .c2   (pix1.second_green),
    .m1   (m1),
    .m2   (m2),
    .ch   (green3)
  );

  rgbab_chan u_blue (
    .clk  (clk),
    .mode (mode1),
    .c1   (pix1.first_blue),
    .c2   (pix1.second_blue),
    .m1   (m1),
    .m2   (m2),
    .ch   (blue3)
  );

  // Result port.
  assign done             = valid3;
  assign result.out_red   = red3;
  assign result.out_green = green3;
  assign result.out_blue  = blue3;
  assign result.out_alpha = alpha3;

`ifndef SYNTHESIS
  // Every accepted item yields a result with done high.
  a_item_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##3 done)
    else $error("accepted item produced no result");

  // No result without an earlier accepted item.
  a_no_phantom: assert property (@(posedge clk)
    done |-> $past(accept, 3))
    else $error("result without an accepted item");

  // In overlay mode the first alpha passes through unchanged.
  a_overlay_alpha: assert property (@(posedge clk) disable iff (rst)
    (accept && overlay_mode) |-> ##3 (result.out_alpha == $past(src.first_alpha, 3)))
    else $error("overlay alpha does not match first alpha");
`endif

endmodule

// ----- hw/rtl/rgbab_chan.sv -----
// One color channel mixer: two registered products, then a registered sum and scale.
`timescale 1ns / 1ps

module rgbab_chan (
  input  logic                        clk,
  input  logic                        mode,
  input  logic [rgbab_pkg::CH_W-1:0]  c1,
  input  logic [rgbab_pkg::CH_W-1:0]  c2,
  input  logic [rgbab_pkg::PROD_W-1:0] m1,
  input  logic [rgbab_pkg::PROD_W-1:0] m2,
  output logic [rgbab_pkg::CH_W-1:0]  ch
);

  logic [rgbab_pkg::MIX_W-1:0] prod1;
  logic [rgbab_pkg::MIX_W-1:0] prod2;
  logic                        mode2;
  logic [rgbab_pkg::MIX_W-1:0] sum;

  // Multiply each color by its weight.
  always_ff @(posedge clk) begin
    prod1 <= {{(rgbab_pkg::MIX_W-rgbab_pkg::CH_W){1'b0}}, c1} *
             {{(rgbab_pkg::MIX_W-rgbab_pkg::PROD_W){1'b0}}, m1};
    prod2 <= {{(rgbab_pkg::MIX_W-rgbab_pkg::CH_W){1'b0}}, c2} *
             {{(rgbab_pkg::MIX_W-rgbab_pkg::PROD_W){1'b0}}, m2};
    mode2 <= mode;
  end

  assign sum = prod1 + prod2;

  // Weighted mode scales by 2^16, overlay mode by 2^8.
  always_ff @(posedge clk) begin
    if (mode2) begin
      ch <= sum[15:8];
    end else begin
      ch <= sum[23:16];
    end
  end

endmodule

// ----- tb/sv/rgba_pixel_alpha_blend_unit_test.sv -----
// Self-checking testbench for the RGBA8 pixel alpha blend unit.
`timescale 1ns / 1ps

module rgba_pixel_alpha_blend_unit_test;

  localparam int PIPE_LAT    = 3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DIR_ROWS    = 19;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 153;

  // One row of the directed table: register setting, pixel pair and,
  // where it is obvious, the blended pixel typed in by hand.
  typedef struct {
    logic                   ovl;
    logic [8:0]             wgt;
    rgbab_pkg::pixel_pair_t pair;
    logic                   typed;
    rgbab_pkg::result_t     want;
  } dir_row_t;

  logic                                  clk;
  logic                                  rst     = 1'b1;
  logic                                  start   = 1'b0;
  rgbab_pkg::pixel_pair_t                src     = '0;
  logic                                  psel    = 1'b0;
  logic                                  penable = 1'b0;
  logic                                  pwrite  = 1'b0;
  logic [rgbab_pkg::ADDR_W-1:0]          paddr   = '0;
  logic [rgbab_pkg::DATA_W-1:0]          pwdata  = '0;
  logic                                  busy;
  logic                                  done;
  rgbab_pkg::result_t                    result;
  logic [rgbab_pkg::DATA_W-1:0]          prdata;
  logic                                  pready;

  // Local copy of the block's registers, kept in step with every write.
  logic                                  cur_overlay = 1'b0;
  logic [8:0]                            cur_weight  = rgbab_pkg::WEIGHT_RESET;

  rgbab_pkg::result_t                    blends_due[$];
  dir_row_t                              rows[DIR_ROWS];
  int                                    errors      = 0;
  int                                    blends_seen = 0;
  int                                    settings    = 0;
  int                                    cycles      = 0;
  logic                                  steady      = 1'b0;

  rgba_pixel_alpha_blend_unit uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .src     (src),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Blended pixel for one pair under the given overlay flag and weight.
  function automatic rgbab_pkg::result_t blend_expected(rgbab_pkg::pixel_pair_t p, logic ovl,
                                                        logic [8:0] wgt);
    int unsigned        wa, wb, w, nw, a1, a2, acc;
    int unsigned        c1[3], c2[3];
    logic [7:0]         mix[3];
    rgbab_pkg::result_t r;
    wa = (wgt > rgbab_pkg::WEIGHT_ONE) ? 32'(rgbab_pkg::WEIGHT_ONE) : 32'(wgt);
    wb = 32'(rgbab_pkg::WEIGHT_ONE) - wa;
    a1 = 32'(p.first_alpha);
    a2 = 32'(p.second_alpha);
    c1 = '{p.first_red, p.first_green, p.first_blue};
    c2 = '{p.second_red, p.second_green, p.second_blue};
    if (!ovl) begin
      // Premultiplied mix of both pixels.
      for (int i = 0; i < 3; i++) begin
        acc    = c1[i] * a1 * wb + c2[i] * a2 * wa;
        mix[i] = 8'(acc >> 16);
      end
      r.out_alpha = 8'((a1 * wb + a2 * wa) >> 8);
    end else begin
      // Second alpha scaled by the weight sets a per-pixel mix.
      w  = (a2 * wa) >> 8;
      nw = 32'(rgbab_pkg::WEIGHT_ONE) - w;
      for (int i = 0; i < 3; i++) begin
        acc    = c1[i] * nw + c2[i] * w;
        mix[i] = 8'(acc >> 8);
      end
      r.out_alpha = p.first_alpha;
    end
    r.out_red   = mix[0];
    r.out_green = mix[1];
    r.out_blue  = mix[2];
    return r;
  endfunction

  // Channel value that favors the extremes.
  function automatic logic [7:0] pick_channel();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Reads one register and compares it with the value it should hold.
  task automatic read_reg(logic idx, logic [rgbab_pkg::DATA_W-1:0] want);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $display("%0t: register %0d read mismatch, expected %0h, got %0h",
               $time, idx, want, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes one register, with junk in the unused upper bits, then reads it back.
  task automatic write_reg(logic idx, logic [8:0] value);
    logic [rgbab_pkg::DATA_W-1:0] data;
    logic [rgbab_pkg::DATA_W-1:0] kept;
    if (idx == rgbab_pkg::REG_OVERLAY) begin
      data        = ($urandom() & 32'hFFFF_FFFE) | {31'd0, value[0]};
      kept        = {31'd0, value[0]};
      cur_overlay = value[0];
    end else begin
      data        = ($urandom() & 32'hFFFF_FE00) | {23'd0, value};
      kept        = {23'd0, value};
      cur_weight  = value;
    end
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    read_reg(idx, kept);
  endtask

  // Waits until every blended pixel has come out and the pipeline is empty.
  task automatic settle();
    start <= 1'b0;
    while (blends_due.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  // Offers one pixel pair, sometimes after a random gap, and records its blend once taken.
  task automatic send_pair(rgbab_pkg::pixel_pair_t p, rgbab_pkg::result_t want);
    if (!steady && $urandom_range(0, 99) < 38) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start <= 1'b1;
    src   <= p;
    do @(posedge clk); while (busy);
    blends_due.push_back(want);
  endtask

  // Applies a register setting, writing only what changed unless force_all is set.
  task automatic apply_setting(logic ovl, logic [8:0] wgt, logic force_all);
    if (force_all || ovl != cur_overlay || wgt != cur_weight) begin
      settle();
      settings++;
    end
    if (force_all || ovl != cur_overlay) write_reg(rgbab_pkg::REG_OVERLAY, {8'd0, ovl});
    if (force_all || wgt != cur_weight) write_reg(rgbab_pkg::REG_WEIGHT, wgt);
  endtask

  // Every blended pixel is checked against the oldest one due.
  always @(posedge clk) begin : check_blend
    rgbab_pkg::result_t want;
    if (!rst && done) begin
      blends_seen++;
      if (blends_due.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, got %08h", $time, result);
        errors++;
      end else begin
        want = blends_due.pop_front();
        if (result.out_red !== want.out_red) begin
          $display("%0t: out_red mismatch, expected %02h, got %02h",
                   $time, want.out_red, result.out_red);
          errors++;
        end
        if (result.out_green !== want.out_green) begin
          $display("%0t: out_green mismatch, expected %02h, got %02h",
                   $time, want.out_green, result.out_green);
          errors++;
        end
        if (result.out_blue !== want.out_blue) begin
          $display("%0t: out_blue mismatch, expected %02h, got %02h",
                   $time, want.out_blue, result.out_blue);
          errors++;
        end
        if (result.out_alpha !== want.out_alpha) begin
          $display("%0t: out_alpha mismatch, expected %02h, got %02h",
                   $time, want.out_alpha, result.out_alpha);
          errors++;
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d pixels outstanding",
               cycles, blends_due.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    rgbab_pkg::pixel_pair_t p;
    rgbab_pkg::result_t     want;
    logic                   ovl;
    logic [8:0]             wgt;
    int unsigned            pick;

    // Directed table: extremes, both modes, weights at and above full scale.
    rows[0]  = '{1'b0, 9'd128, 64'h00000000_00000000, 1'b1, 32'h00000000};
    rows[1]  = '{1'b0, 9'd128, 64'hFFFFFFFF_FFFFFFFF, 1'b1, 32'hFEFEFEFF};
    rows[2]  = '{1'b0, 9'd128, 64'hFFFFFFFF_00000000, 1'b1, 32'h7F7F7F7F};
    rows[3]  = '{1'b0, 9'd0,   64'h123456FF_ABCDEF80, 1'b0, 32'h0};
    rows[4]  = '{1'b0, 9'd0,   64'hFFFFFFFF_00000000, 1'b1, 32'hFEFEFEFF};
    rows[5]  = '{1'b0, 9'd256, 64'h00000000_FFFFFFFF, 1'b1, 32'hFEFEFEFF};
    rows[6]  = '{1'b0, 9'd256, 64'h9C3E71D2_4BF0A617, 1'b0, 32'h0};
    rows[7]  = '{1'b0, 9'd300, 64'h00000000_FFFFFFFF, 1'b1, 32'hFEFEFEFF};
    rows[8]  = '{1'b0, 9'd511, 64'h0000FFFF_FFFFFF80, 1'b0, 32'h0};
    rows[9]  = '{1'b1, 9'd256, 64'hFFFFFFFF_FFFFFFFF, 1'b1, 32'hFFFFFFFF};
    rows[10] = '{1'b1, 9'd256, 64'h00000000_FFFFFFFF, 1'b1, 32'hFEFEFE00};
    rows[11] = '{1'b1, 9'd256, 64'hFFFFFF7F_00000000, 1'b1, 32'hFFFFFF7F};
    rows[12] = '{1'b1, 9'd0,   64'h10203040_F0E0D0FF, 1'b1, 32'h10203040};
    rows[13] = '{1'b1, 9'd128, 64'h80402010_01020355, 1'b0, 32'h0};
    rows[14] = '{1'b1, 9'd384, 64'h3377BBFF_CC884400, 1'b0, 32'h0};
    rows[15] = '{1'b1, 9'd1,   64'hA5A5A5A5_5A5A5A5A, 1'b0, 32'h0};
    rows[16] = '{1'b0, 9'd255, 64'h5A5A5A5A_A5A5A5A5, 1'b0, 32'h0};
    rows[17] = '{1'b0, 9'd1,   64'hE1C3A5FF_1E3C5AFF, 1'b0, 32'h0};
    rows[18] = '{1'b0, 9'd128, 64'h55AA55AA_AA55AA55, 1'b0, 32'h0};

    // Reset, then check that the registers come up at their defaults.
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    read_reg(rgbab_pkg::REG_OVERLAY, 32'd0);
    read_reg(rgbab_pkg::REG_WEIGHT, {23'd0, rgbab_pkg::WEIGHT_RESET});

    foreach (rows[i]) begin
      apply_setting(rows[i].ovl, rows[i].wgt, 1'b0);
      want = rows[i].typed ? rows[i].want
                           : blend_expected(rows[i].pair, cur_overlay, cur_weight);
      send_pair(rows[i].pair, want);
    end

    // Random phases, each under its own setting; the first few pin the extremes.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin ovl = 1'b0; wgt = 9'd0;   end
        1: begin ovl = 1'b1; wgt = 9'd256; end
        2: begin ovl = 1'b0; wgt = 9'd511; end
        3: begin ovl = 1'b1; wgt = 9'd0;   end
        default: begin
          ovl  = 1'($urandom_range(0, 1));
          pick = $urandom_range(0, 9);
          if (pick == 0)      wgt = 9'd0;
          else if (pick == 1) wgt = 9'd256;
          else if (pick == 2) wgt = 9'($urandom_range(257, 511));
          else                wgt = 9'($urandom_range(1, 255));
        end
      endcase
      apply_setting(ovl, wgt, 1'b1);
      // One phase runs back to back with no gaps at all.
      steady = (ph == 5);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        p = {pick_channel(), pick_channel(), pick_channel(), pick_channel(),
             pick_channel(), pick_channel(), pick_channel(), pick_channel()};
        send_pair(p, blend_expected(p, cur_overlay, cur_weight));
      end
    end
    steady = 1'b0;

    settle();
    $display("Ran %0d directed and %0d random pixel pairs over %0d register settings.",
             DIR_ROWS, PHASES * PHASE_ITEMS, settings);
    $display("Checked %0d blended pixels in both modes, weights 0 through 511.",
             blends_seen);
    if (errors == 0 && blends_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/rgbab_pkg.sv
hw/rtl/rgbab_chan.sv
hw/rtl/rgba_pixel_alpha_blend_unit.sv
tb/sv/rgba_pixel_alpha_blend_unit_test.sv
